// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ===== hdl/stw_pkg.sv =====
package stw_pkg;

    localparam logic CMD_TRANSLATE = 1'b0;
    localparam logic CMD_REPLY     = 1'b1;

    localparam logic KIND_FETCH = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    localparam logic [2:0] FAULT_NONE        = 3'd0;
    localparam logic [2:0] FAULT_ADDR_SIZE   = 3'd1;
    localparam logic [2:0] FAULT_TRANSLATION = 3'd2;
    localparam logic [2:0] FAULT_ACCESS_FLAG = 3'd3;
    localparam logic [2:0] FAULT_PERMISSION  = 3'd4;

    localparam logic [1:0] CFG_MMU_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_LOW_BASE    = 2'd1;
    localparam logic [1:0] CFG_HIGH_BASE   = 2'd2;
    localparam logic [1:0] CFG_TRANS_CTRL  = 2'd3;

    localparam logic [1:0] TG0_4K = 2'b00;
    localparam logic [1:0] TG1_4K = 2'b10;

    localparam logic [1:0] DESC_KIND_BLOCK = 2'b01;
    localparam logic [1:0] DESC_KIND_TABLE = 2'b11;

    localparam logic [1:0] LEVEL_0 = 2'd0;
    localparam logic [1:0] LEVEL_1 = 2'd1;
    localparam logic [1:0] LEVEL_2 = 2'd2;
    localparam logic [1:0] LEVEL_3 = 2'd3;

    typedef struct packed {
        logic        mmu_enable;
        logic [63:0] low_base;
        logic [63:0] high_base;
        logic [63:0] trans_ctrl;
    } t_cfg;

    typedef struct packed {
        logic        busy;
        logic [1:0]  level;
        logic [63:0] saved_address;
        logic        saved_write;
    } t_walk_state;

    typedef struct packed {
        logic        command;
        logic [63:0] virtual_address;
        logic        write_access;
        logic [63:0] descriptor;
        logic        read_error;
    } t_item;

    typedef struct packed {
        logic        result_kind;
        logic [63:0] fetch_address;
        logic        success;
        logic [63:0] phys_address;
        logic [2:0]  fault_type;
        logic [1:0]  fault_level;
    } t_result;

    // Descriptor address for a table at the given level.
    function automatic logic [63:0] fetch_addr(input logic [63:0] table_word,
                                               input logic [63:0] va,
                                               input logic [1:0]  level);
        logic [8:0] idx;
        case (level)
            LEVEL_0: idx = va[47:39];
            LEVEL_1: idx = va[38:30];
            LEVEL_2: idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return {16'h0000, table_word[47:12], idx, 3'b000};
    endfunction

endpackage

// ===== hdl/stw_step.sv =====
module stw_step (
    input  stw_pkg::t_cfg        i_cfg,
    input  stw_pkg::t_walk_state i_state,
    input  stw_pkg::t_item       i_item,
    output logic                 o_emit,
    output stw_pkg::t_result     o_result,
    output stw_pkg::t_walk_state o_state
);

    logic        upper;
    logic [5:0]  sz;
    logic [1:0]  tg;
    logic        disabled;
    logic        bad_granule;
    logic [6:0]  vbits;
    logic [63:0] hi_mask;
    logic        non_canonical;
    logic [1:0]  entry_level;
    logic [1:0]  lv;
    logic [1:0]  desc_kind;
    logic [63:0] leaf_pa;

    always_comb begin
        upper = i_item.virtual_address[63];
        if (upper) begin
            sz          = i_cfg.trans_ctrl[21:16];
            tg          = i_cfg.trans_ctrl[31:30];
            bad_granule = (tg != stw_pkg::TG1_4K);
            disabled    = i_cfg.trans_ctrl[23];
        end else begin
            sz          = i_cfg.trans_ctrl[5:0];
            tg          = i_cfg.trans_ctrl[15:14];
            bad_granule = (tg != stw_pkg::TG0_4K);
            disabled    = i_cfg.trans_ctrl[7];
        end
        vbits         = 7'd64 - {1'b0, sz};
        hi_mask       = {64{1'b1}} << vbits;
        non_canonical = ((i_item.virtual_address ^ {64{upper}}) & hi_mask) != 64'd0;
        if (sz <= 6'd24) begin
            entry_level = stw_pkg::LEVEL_0;
        end else if (sz <= 6'd33) begin
            entry_level = stw_pkg::LEVEL_1;
        end else if (sz <= 6'd42) begin
            entry_level = stw_pkg::LEVEL_2;
        end else begin
            entry_level = stw_pkg::LEVEL_3;
        end
    end

    always_comb begin
        lv        = i_state.level;
        desc_kind = i_item.descriptor[1:0];
        case (lv)
            stw_pkg::LEVEL_1: leaf_pa = {16'h0000, i_item.descriptor[47:30],
                                         i_state.saved_address[29:0]};
            stw_pkg::LEVEL_2: leaf_pa = {16'h0000, i_item.descriptor[47:21],
                                         i_state.saved_address[20:0]};
            default:          leaf_pa = {16'h0000, i_item.descriptor[47:12],
                                         i_state.saved_address[11:0]};
        endcase
    end

    always_comb begin
        o_emit   = 1'b1;
        o_state  = i_state;
        o_result = '0;
        o_result.result_kind = stw_pkg::KIND_DONE;
        if (i_item.command == stw_pkg::CMD_TRANSLATE) begin
            o_state.busy = 1'b0;
            if (!i_cfg.mmu_enable) begin
                o_result.success      = 1'b1;
                o_result.phys_address = {16'h0000, i_item.virtual_address[47:0]};
            end else if (bad_granule || disabled || sz < 6'd16 || sz > 6'd51
                         || non_canonical) begin
                o_result.fault_type = stw_pkg::FAULT_ADDR_SIZE;
            end else begin
                o_state.busy          = 1'b1;
                o_state.level         = entry_level;
                o_state.saved_address = i_item.virtual_address;
                o_state.saved_write   = i_item.write_access;
                o_result.result_kind   = stw_pkg::KIND_FETCH;
                o_result.fetch_address = stw_pkg::fetch_addr(
                    upper ? i_cfg.high_base : i_cfg.low_base,
                    i_item.virtual_address, entry_level);
            end
        end else if (!i_state.busy) begin
            o_emit = 1'b0;
        end else begin
            o_state.busy = 1'b0;
            if (i_item.read_error || !i_item.descriptor[0]) begin
                o_result.fault_type  = stw_pkg::FAULT_TRANSLATION;
                o_result.fault_level = lv;
            end else if (lv != stw_pkg::LEVEL_3 && desc_kind == stw_pkg::DESC_KIND_TABLE) begin
                o_state.busy           = 1'b1;
                o_state.level          = lv + 2'd1;
                o_result.result_kind   = stw_pkg::KIND_FETCH;
                o_result.fetch_address = stw_pkg::fetch_addr(
                    i_item.descriptor, i_state.saved_address, lv + 2'd1);
            end else if ((lv == stw_pkg::LEVEL_3 && desc_kind != stw_pkg::DESC_KIND_TABLE)
                         || (lv != stw_pkg::LEVEL_3
                             && desc_kind != stw_pkg::DESC_KIND_BLOCK)
                         || lv == stw_pkg::LEVEL_0) begin
                o_result.fault_type  = stw_pkg::FAULT_TRANSLATION;
                o_result.fault_level = lv;
            end else if (!i_item.descriptor[10]) begin
                o_result.fault_type  = stw_pkg::FAULT_ACCESS_FLAG;
                o_result.fault_level = lv;
            end else if (i_state.saved_write && i_item.descriptor[7]) begin
                o_result.fault_type  = stw_pkg::FAULT_PERMISSION;
                o_result.fault_level = lv;
            end else begin
                o_result.success      = 1'b1;
                o_result.phys_address = leaf_pa;
            end
        end
    end

endmodule

// ===== hdl/stage1_table_walker_4k.sv =====
// Stage-1 table walker for a 4 KiB granule.
// Requests arrive on the input valid/ready channel: command 0 is a translate
// request, command 1 the reply to the last descriptor fetch. Each request
// gives at most one result on the output valid/ready channel: either a
// descriptor fetch request (result kind 0) or a finished translation with
// its physical address or fault (result kind 1). A reply that arrives while
// no walk is in progress is dropped without a result.
// A request is held in an input register, then evaluated combinationally into
// the output register, from which its result is offered; one request per cycle
// is taken while the output is drained.
// When the receiver stalls, the result holds and the input register keeps one
// further request; input ready then falls until the result is taken.
// Configuration is written through the write port; the user must write it
// only while the block is idle; the block does not enforce it. Synchronous
// reset clears config, walk state and both valid flags, leaving input ready.
module stage1_table_walker_4k (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [63:0] i_virtual_address,
    input  logic        i_write_access,
    input  logic [63:0] i_descriptor,
    input  logic        i_read_error,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_result_kind,
    output logic [63:0] o_fetch_address,
    output logic        o_success,
    output logic [63:0] o_phys_address,
    output logic [2:0]  o_fault_type,
    output logic [1:0]  o_fault_level
);

    stw_pkg::t_cfg        r_cfg;
    stw_pkg::t_walk_state r_state;
    stw_pkg::t_walk_state n_state;
    stw_pkg::t_item       r_item;
    stw_pkg::t_result     r_result;
    stw_pkg::t_result     n_result;
    logic                 r_in_valid;
    logic                 r_out_valid;
    logic                 emit;
    logic                 advance;
    logic                 in_accept;

    stw_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_emit   (emit),
        .o_result (n_result),
        .o_state  (n_state)
    );

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= '0;
            r_state     <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    stw_pkg::CFG_MMU_ENABLE: r_cfg.mmu_enable <= i_cfg_data[0];
                    stw_pkg::CFG_LOW_BASE:   r_cfg.low_base   <= i_cfg_data;
                    stw_pkg::CFG_HIGH_BASE:  r_cfg.high_base  <= i_cfg_data;
                    stw_pkg::CFG_TRANS_CTRL: r_cfg.trans_ctrl <= i_cfg_data;
                    default:                 r_cfg            <= r_cfg;
                endcase
            end
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.command         <= i_command;
            r_item.virtual_address <= i_virtual_address;
            r_item.write_access    <= i_write_access;
            r_item.descriptor      <= i_descriptor;
            r_item.read_error      <= i_read_error;
        end
        if (advance && emit) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_result.result_kind;
    assign o_fetch_address = r_result.fetch_address;
    assign o_success       = r_result.success;
    assign o_phys_address  = r_result.phys_address;
    assign o_fault_type    = r_result.fault_type;
    assign o_fault_level   = r_result.fault_level;

endmodule

// ===== hdl/stw_checker.sv =====
`include "assert_macros.svh"

module stw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_result_kind,
    input logic [63:0] o_fetch_address,
    input logic        o_success,
    input logic [63:0] o_phys_address,
    input logic [2:0]  o_fault_type,
    input logic [1:0]  o_fault_level
);

    // A stalled result stays offered and unchanged.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_kind)
        && $stable(o_fetch_address) && $stable(o_phys_address)
        && $stable(o_fault_type) && $stable(o_fault_level) && $stable(o_success))

    // With the output register empty, a new request can always be taken.
    `ASSERT_CLK(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready)

    // A fetch request carries no translation outcome.
    `ASSERT_CLK(a_fetch_clean, i_clk, i_rst_n,
        o_out_valid && o_result_kind == stw_pkg::KIND_FETCH |->
        !o_success && o_phys_address == 64'd0
        && o_fault_type == stw_pkg::FAULT_NONE)

    // Success and a fault never come together, and a success has no level.
    `ASSERT_CLK(a_done_consistent, i_clk, i_rst_n,
        o_out_valid && o_result_kind == stw_pkg::KIND_DONE && o_success |->
        o_fault_type == stw_pkg::FAULT_NONE && o_fault_level == 2'd0)

    // Input ready is held back only while a result is stalled.
    `ASSERT_CLK(a_ready_stall, i_clk, i_rst_n,
        !o_in_ready |-> o_out_valid && !i_out_ready)

endmodule

bind stage1_table_walker_4k stw_checker u_stw_checker (.*);

// ===== dv/stage1_table_walker_4k_tb.sv =====
module stage1_table_walker_4k_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] OA_MASK     = 64'h0000_FFFF_FFFF_F000;
    localparam logic [63:0] FLAT_MASK   = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [1:0]  TG0_64K     = 2'b01;
    localparam logic [1:0]  TG0_16K     = 2'b10;
    localparam logic [1:0]  TG1_16K     = 2'b01;
    localparam logic [1:0]  TG1_64K     = 2'b11;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned LATENCY     = 4;
    localparam int unsigned PRINT_LIMIT = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_command;
    logic [63:0] i_virtual_address;
    logic        i_write_access;
    logic [63:0] i_descriptor;
    logic        i_read_error;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_result_kind;
    logic [63:0] o_fetch_address;
    logic        o_success;
    logic [63:0] o_phys_address;
    logic [2:0]  o_fault_type;
    logic [1:0]  o_fault_level;

    stw_pkg::t_cfg        cfg_model;
    stw_pkg::t_walk_state walk;
    stw_pkg::t_result     awaited_results[$];
    stw_pkg::t_result     got_want;
    int unsigned mismatches = 0;
    int unsigned walk_items = 0;
    int unsigned idle_cycles = 0;
    int unsigned sink_hold_cycles = 0;
    bit          source_gaps_on = 1'b1;
    bit          sink_gaps_on = 1'b1;

    stage1_table_walker_4k dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_command          (i_command),
        .i_virtual_address  (i_virtual_address),
        .i_write_access     (i_write_access),
        .i_descriptor       (i_descriptor),
        .i_read_error       (i_read_error),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_result_kind      (o_result_kind),
        .o_fetch_address    (o_fetch_address),
        .o_success          (o_success),
        .o_phys_address     (o_phys_address),
        .o_fault_type       (o_fault_type),
        .o_fault_level      (o_fault_level)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int unsigned level_shift(input logic [1:0] lvl);
        return 12 + 9 * (3 - int'(lvl));
    endfunction

    function automatic logic [63:0] descriptor_address(input logic [63:0] base,
                                                       input logic [63:0] va,
                                                       input logic [1:0]  lvl);
        logic [63:0] slot;
        slot = (va >> level_shift(lvl)) & 64'h1ff;
        return (base & OA_MASK) + (slot << 3);
    endfunction

    task automatic push_fetch(input logic [63:0] addr);
        stw_pkg::t_result r;
        r = '0;
        r.result_kind = stw_pkg::KIND_FETCH;
        r.fetch_address = addr;
        awaited_results.push_back(r);
    endtask

    task automatic push_done(input logic ok, input logic [63:0] pa,
                             input logic [2:0] fault, input logic [1:0] lvl);
        stw_pkg::t_result r;
        r = '0;
        r.result_kind = stw_pkg::KIND_DONE;
        r.success = ok;
        r.phys_address = ok ? pa : 64'd0;
        r.fault_type = fault;
        r.fault_level = lvl;
        awaited_results.push_back(r);
        walk.busy = 1'b0;
    endtask

    task automatic predict_walk_step(input logic cmd, input logic [63:0] va, input logic wr,
                                     input logic [63:0] desc, input logic err);
        logic        upper;
        logic        disabled;
        logic        bad_granule;
        logic [5:0]  size;
        int unsigned vbits;
        logic [63:0] va_mask;
        logic [63:0] offset_mask;
        logic [1:0]  lvl;
        if (cmd == stw_pkg::CMD_TRANSLATE) begin
            walk_items++;
            walk.busy = 1'b0;
            upper = va[63];
            if (upper) begin
                size = cfg_model.trans_ctrl[21:16];
                bad_granule = cfg_model.trans_ctrl[31:30] != stw_pkg::TG1_4K;
                disabled = cfg_model.trans_ctrl[23];
            end else begin
                size = cfg_model.trans_ctrl[5:0];
                bad_granule = cfg_model.trans_ctrl[15:14] != stw_pkg::TG0_4K;
                disabled = cfg_model.trans_ctrl[7];
            end
            vbits = 64 - int'(size);
            if (!cfg_model.mmu_enable) begin
                push_done(1'b1, va & FLAT_MASK, stw_pkg::FAULT_NONE, stw_pkg::LEVEL_0);
            end else if (bad_granule || disabled || vbits <= 12 || vbits > 48) begin
                push_done(1'b0, 64'd0, stw_pkg::FAULT_ADDR_SIZE, stw_pkg::LEVEL_0);
            end else begin
                va_mask = (64'd1 << vbits) - 64'd1;
                if ((va & ~va_mask) != (upper ? ~va_mask : 64'd0)) begin
                    push_done(1'b0, 64'd0, stw_pkg::FAULT_ADDR_SIZE, stw_pkg::LEVEL_0);
                end else begin
                    walk.busy = 1'b1;
                    walk.level = 2'(4 - (vbits - 4) / 9);
                    walk.saved_address = va;
                    walk.saved_write = wr;
                    push_fetch(descriptor_address(upper ? cfg_model.high_base
                                                        : cfg_model.low_base,
                                                  va, walk.level));
                end
            end
        end else if (walk.busy) begin
            walk_items++;
            lvl = walk.level;
            if (err || !desc[0]) begin
                push_done(1'b0, 64'd0, stw_pkg::FAULT_TRANSLATION, lvl);
            end else if (lvl != stw_pkg::LEVEL_3 && desc[1:0] == stw_pkg::DESC_KIND_TABLE) begin
                walk.level = lvl + 2'd1;
                push_fetch(descriptor_address(desc, walk.saved_address, walk.level));
            end else if ((lvl == stw_pkg::LEVEL_3 && desc[1:0] != stw_pkg::DESC_KIND_TABLE) ||
                         (lvl != stw_pkg::LEVEL_3 && desc[1:0] != stw_pkg::DESC_KIND_BLOCK) ||
                         lvl == stw_pkg::LEVEL_0) begin
                push_done(1'b0, 64'd0, stw_pkg::FAULT_TRANSLATION, lvl);
            end else if (!desc[10]) begin
                push_done(1'b0, 64'd0, stw_pkg::FAULT_ACCESS_FLAG, lvl);
            end else if (walk.saved_write && desc[7]) begin
                push_done(1'b0, 64'd0, stw_pkg::FAULT_PERMISSION, lvl);
            end else begin
                offset_mask = (64'd1 << level_shift(lvl)) - 64'd1;
                push_done(1'b1, (desc & OA_MASK & ~offset_mask) |
                                (walk.saved_address & offset_mask), stw_pkg::FAULT_NONE,
                          stw_pkg::LEVEL_0);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unrequested result", 64'(o_result_kind), 64'd0);
            end else begin
                got_want = awaited_results.pop_front();
                if (o_result_kind !== got_want.result_kind)
                    report_mismatch("result_kind", 64'(o_result_kind),
                                    64'(got_want.result_kind));
                if (o_fetch_address !== got_want.fetch_address)
                    report_mismatch("fetch_address", o_fetch_address, got_want.fetch_address);
                if (o_success !== got_want.success)
                    report_mismatch("success", 64'(o_success), 64'(got_want.success));
                if (o_phys_address !== got_want.phys_address)
                    report_mismatch("phys_address", o_phys_address, got_want.phys_address);
                if (o_fault_type !== got_want.fault_type)
                    report_mismatch("fault_type", 64'(o_fault_type), 64'(got_want.fault_type));
                if (o_fault_level !== got_want.fault_level)
                    report_mismatch("fault_level", 64'(o_fault_level),
                                    64'(got_want.fault_level));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("stage1_table_walker_4k test failed");
            $finish;
        end
    end

    initial begin : sink_driver
        int unsigned hold;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_cycles != 0) begin
                hold = sink_hold_cycles;
                sink_hold_cycles = 0;
                i_out_ready <= 1'b0;
                repeat (hold - 1) @(negedge i_clk);
            end else if (sink_gaps_on && $urandom_range(0, 11) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(0, 18)) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic offer_request(input logic cmd, input logic [63:0] va, input logic wr,
                                 input logic [63:0] desc, input logic err);
        int unsigned gap;
        if (source_gaps_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_virtual_address <= va;
        i_write_access <= wr;
        i_descriptor <= desc;
        i_read_error <= err;
        do @(posedge i_clk); while (!o_in_ready);
        predict_walk_step(cmd, va, wr, desc, err);
    endtask

    task automatic offer_translate(input logic [63:0] va, input logic wr);
        offer_request(stw_pkg::CMD_TRANSLATE, va, wr, rand64(), 1'($urandom_range(0, 1)));
    endtask

    task automatic offer_reply(input logic [63:0] desc, input logic err);
        offer_request(stw_pkg::CMD_REPLY, rand64(), 1'($urandom_range(0, 1)), desc, err);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] reg_index, input logic [63:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= reg_index;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (reg_index)
            stw_pkg::CFG_MMU_ENABLE: cfg_model.mmu_enable = value[0];
            stw_pkg::CFG_LOW_BASE:   cfg_model.low_base = value;
            stw_pkg::CFG_HIGH_BASE:  cfg_model.high_base = value;
            stw_pkg::CFG_TRANS_CTRL: cfg_model.trans_ctrl = value;
            default: ;
        endcase
    endtask

    function automatic logic [63:0] tcr_value(input logic [5:0] t0sz, input logic [5:0] t1sz,
                                              input logic epd0, input logic epd1,
                                              input logic [1:0] tg0, input logic [1:0] tg1);
        logic [63:0] v;
        v = rand64();
        v[5:0] = t0sz;
        v[7] = epd0;
        v[15:14] = tg0;
        v[21:16] = t1sz;
        v[23] = epd1;
        v[31:30] = tg1;
        return v;
    endfunction

    function automatic logic [63:0] make_descriptor(input logic [63:0] oa, input logic [1:0] kind,
                                                    input logic af, input logic ro);
        logic [63:0] d;
        d = rand64();
        d[47:12] = oa[47:12];
        d[1:0] = kind;
        d[10] = af;
        d[7] = ro;
        return d;
    endfunction

    function automatic logic [63:0] random_va();
        logic [63:0] va;
        logic [63:0] keep;
        logic [5:0]  size;
        va = rand64();
        size = va[63] ? cfg_model.trans_ctrl[21:16] : cfg_model.trans_ctrl[5:0];
        keep = (size == 6'd0) ? '1 : (64'd1 << (64 - int'(size))) - 64'd1;
        if ($urandom_range(0, 19) != 0)
            va = va[63] ? (va | ~keep) : (va & keep);
        return va;
    endfunction

    function automatic logic [63:0] next_descriptor();
        logic [63:0] d;
        int unsigned pick;
        d = rand64();
        pick = $urandom_range(0, 99);
        if (pick < 55)
            d[1:0] = stw_pkg::DESC_KIND_TABLE;
        else if (pick < 85)
            d[1:0] = stw_pkg::DESC_KIND_BLOCK;
        d[10] = $urandom_range(0, 9) != 0;
        return d;
    endfunction

    task automatic random_walk();
        offer_translate(random_va(), 1'($urandom_range(0, 1)));
        while (walk.busy && $urandom_range(0, 24) != 0) begin
            if (source_gaps_on && $urandom_range(0, 59) == 0)
                wait_for_results();
            offer_reply(next_descriptor(), $urandom_range(0, 29) == 0);
        end
    endtask

    task automatic load_random_setup();
        logic [63:0] v;
        v = rand64();
        v[0] = $urandom_range(0, 9) != 0;
        write_register(stw_pkg::CFG_MMU_ENABLE, v);
        case ($urandom_range(0, 7))
            0: write_register(stw_pkg::CFG_LOW_BASE, '0);
            1: write_register(stw_pkg::CFG_LOW_BASE, '1);
            default: write_register(stw_pkg::CFG_LOW_BASE, rand64());
        endcase
        case ($urandom_range(0, 7))
            0: write_register(stw_pkg::CFG_HIGH_BASE, '0);
            1: write_register(stw_pkg::CFG_HIGH_BASE, '1);
            default: write_register(stw_pkg::CFG_HIGH_BASE, rand64());
        endcase
        if ($urandom_range(0, 7) == 0)
            write_register(stw_pkg::CFG_TRANS_CTRL, rand64());
        else
            write_register(stw_pkg::CFG_TRANS_CTRL,
                           tcr_value(6'($urandom_range(16, 51)), 6'($urandom_range(16, 51)),
                                     1'b0, 1'b0, stw_pkg::TG0_4K, stw_pkg::TG1_4K));
    endtask

    task automatic test_flat_mapping();
        offer_translate(64'd0, 1'b1);
        offer_translate('1, 1'b0);
        offer_reply('1, 1'b1);
    endtask

    task automatic test_directed_walks();
        logic [63:0] va;
        logic [63:0] tbl;
        va = 64'h0000_7F12_3456_789A;
        tbl = make_descriptor(64'h0000_0000_0004_0000, stw_pkg::DESC_KIND_TABLE, 1'b1, 1'b0);
        wait_for_results();
        write_register(stw_pkg::CFG_MMU_ENABLE, 64'd1);
        write_register(stw_pkg::CFG_LOW_BASE, '1);
        write_register(stw_pkg::CFG_HIGH_BASE, 64'h0000_1234_5678_9000);
        write_register(stw_pkg::CFG_TRANS_CTRL,
                       tcr_value(6'd16, 6'd25, 1'b0, 1'b0, stw_pkg::TG0_4K, stw_pkg::TG1_4K));
        offer_translate(va, 1'b1);
        wait_for_results();
        offer_reply(tbl, 1'b0);
        offer_reply(make_descriptor(64'h0000_8000_0002_0000, stw_pkg::DESC_KIND_TABLE,
                                    1'b0, 1'b1), 1'b0);
        offer_reply(tbl, 1'b0);
        offer_reply(make_descriptor(64'h0000_ABCD_EF01_2000, stw_pkg::DESC_KIND_TABLE,
                                    1'b1, 1'b1), 1'b0);
        offer_translate(64'h0000_FFFF_FFFF_FFFF, 1'b0);
        offer_reply(make_descriptor('1, stw_pkg::DESC_KIND_BLOCK, 1'b1, 1'b0), 1'b0);
        offer_translate(va, 1'b0);
        offer_reply(tbl, 1'b0);
        offer_reply(make_descriptor(64'h0000_FFFF_C000_0000, stw_pkg::DESC_KIND_BLOCK,
                                    1'b1, 1'b1), 1'b0);
        offer_translate(va, 1'b1);
        offer_reply(tbl, 1'b0);
        offer_reply(make_descriptor(64'h0000_0000_4000_0000, stw_pkg::DESC_KIND_BLOCK,
                                    1'b0, 1'b0), 1'b0);
        offer_translate(va, 1'b0);
        offer_reply(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
        offer_translate(va, 1'b0);
        offer_reply('1, 1'b1);
        offer_translate(64'h0001_0000_0000_0000, 1'b0);
        offer_translate(va, 1'b0);
        offer_translate(64'hFFFF_FF80_0000_0000, 1'b1);
        offer_reply(make_descriptor(64'h0000_0123_4000_0000, stw_pkg::DESC_KIND_BLOCK,
                                    1'b1, 1'b0), 1'b0);
        offer_reply(rand64(), 1'b0);
    endtask

    task automatic fault_phase(input logic [63:0] tcr);
        wait_for_results();
        write_register(stw_pkg::CFG_TRANS_CTRL, tcr);
        offer_translate(64'd0, 1'b0);
        offer_translate('1, 1'b1);
    endtask

    task automatic test_address_size_faults();
        wait_for_results();
        write_register(stw_pkg::CFG_TRANS_CTRL,
                       tcr_value(6'd51, 6'd51, 1'b0, 1'b0, stw_pkg::TG0_4K, stw_pkg::TG1_4K));
        offer_translate(64'h0000_0000_0000_1FFF, 1'b0);
        offer_reply(make_descriptor(64'h0000_FFFF_FFFF_F000, stw_pkg::DESC_KIND_BLOCK,
                                    1'b1, 1'b0), 1'b0);
        offer_translate(64'hFFFF_FFFF_FFFF_E000, 1'b1);
        offer_translate(64'h0000_0000_0000_2000, 1'b0);
        fault_phase(tcr_value(6'd52, 6'd15, 1'b0, 1'b0, stw_pkg::TG0_4K, stw_pkg::TG1_4K));
        fault_phase(tcr_value(6'd0, 6'd63, 1'b0, 1'b0, stw_pkg::TG0_4K, stw_pkg::TG1_4K));
        fault_phase(tcr_value(6'd16, 6'd16, 1'b1, 1'b1, stw_pkg::TG0_4K, stw_pkg::TG1_4K));
        fault_phase(tcr_value(6'd16, 6'd16, 1'b0, 1'b0, TG0_16K, TG1_16K));
        fault_phase(tcr_value(6'd16, 6'd16, 1'b0, 1'b0, TG0_64K, TG1_64K));
        fault_phase('1);
        wait_for_results();
        write_register(stw_pkg::CFG_MMU_ENABLE, 64'd0);
        offer_translate(rand64(), 1'b1);
        wait_for_results();
        write_register(stw_pkg::CFG_MMU_ENABLE, '1);
    endtask

    task automatic test_output_backpressure();
        wait_for_results();
        source_gaps_on = 1'b0;
        sink_hold_cycles = 80;
        repeat (60) offer_translate(random_va(), 1'($urandom_range(0, 1)));
        source_gaps_on = 1'b1;
        wait_for_results();
    endtask

    task automatic test_random_walks(input int unsigned phases, input int unsigned per_phase);
        int unsigned target;
        repeat (phases) begin
            wait_for_results();
            load_random_setup();
            target = walk_items + per_phase;
            while (walk_items < target) begin
                if ($urandom_range(0, 9) != 0)
                    random_walk();
                else if ($urandom_range(0, 1) == 0)
                    offer_request(stw_pkg::CMD_REPLY, rand64(), 1'($urandom_range(0, 1)),
                                  rand64(), 1'($urandom_range(0, 1)));
                else
                    offer_translate(rand64(), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = stw_pkg::CFG_MMU_ENABLE;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_command = stw_pkg::CMD_TRANSLATE;
        i_virtual_address = '0;
        i_write_access = 1'b0;
        i_descriptor = '0;
        i_read_error = 1'b0;
        cfg_model = '0;
        walk = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_flat_mapping();
        test_directed_walks();
        test_address_size_faults();
        test_output_backpressure();
        test_random_walks(7, 200);
        source_gaps_on = 1'b0;
        sink_gaps_on = 1'b0;
        test_random_walks(1, 300);
        wait_for_results();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("stage1_table_walker_4k test passed");
        else
            $display("stage1_table_walker_4k test failed");
        $finish;
    end

endmodule
